### rtl/transfer_function_lut_entry_core_assert.svh
// Assertion macros shared by the transfer function lookup RTL
`ifndef TRANSFER_FUNCTION_LUT_ENTRY_CORE_ASSERT_SVH
`define TRANSFER_FUNCTION_LUT_ENTRY_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define TFLE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define TFLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tfle_pkg.sv
// Types, constants and codes of the transfer function lookup block
`default_nettype none

package tfle_pkg;

   localparam int MAX_KEYS       = 16;
   localparam int MAX_TABLE_SIZE = 1024;

   localparam int KEY_IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

   localparam int POS_W      = 16;
   localparam int COLOR_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 4;
   localparam int SLOT_W     = 4;
   localparam int INDEX_W    = 10;
   localparam int THR_W      = 16;
   localparam int SIZE_W     = 11;
   localparam int KCOUNT_W   = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [THR_W-1:0]    LEFT_THR_RESET  = THR_W'(0);
   localparam logic [THR_W-1:0]    RIGHT_THR_RESET = THR_W'(65535);
   localparam logic [SIZE_W-1:0]   SIZE_RESET      = SIZE_W'(256);
   localparam logic [KCOUNT_W-1:0] KCOUNT_RESET    = KCOUNT_W'(0);

   localparam logic [SIZE_W-1:0]   SIZE_MIN  = SIZE_W'(2);
   localparam logic [SIZE_W-1:0]   SIZE_MAX  = SIZE_W'(MAX_TABLE_SIZE);
   localparam logic [KCOUNT_W-1:0] COUNT_MAX = KCOUNT_W'(MAX_KEYS);

   // cut = (thr * size + half) >> THR_W
   localparam int CUT_PROD_W = THR_W + SIZE_W;
   localparam int CUT_SUM_W  = CUT_PROD_W + 1;
   localparam int CUT_W      = CUT_SUM_W - THR_W;
   localparam logic [CUT_SUM_W-1:0] CUT_HALF = CUT_SUM_W'(1) << (THR_W - 1);

   // restoring divider, shared by position and channel divides
   localparam int DIV_NUM_W = INDEX_W + POS_W + 1;
   localparam int DIV_DEN_W = POS_W;
   localparam int DIV_REM_W = POS_W + 1;
   localparam int POS_Q_W   = POS_W + 1;
   localparam int CHAN_Q_W  = CHAN_W;
   localparam int DIV_CNT_W = $clog2(POS_Q_W + 1);
   localparam int PROD_W    = CHAN_W + POS_W;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LEFT_THR   = 2'd0,
      CSR_RIGHT_THR  = 2'd1,
      CSR_TABLE_SIZE = 2'd2,
      CSR_KEY_COUNT  = 2'd3
   } csr_addr_type;

   typedef enum logic {
      REQ_WRITE_KEY = 1'b0,
      REQ_LOOKUP    = 1'b1
   } req_kind_type;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_RANGE = 1'b1
   } status_type;

   typedef enum logic {
      DIV_POS  = 1'b0,
      DIV_CHAN = 1'b1
   } div_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CUTS,
      ST_CHECK,
      ST_POS_WAIT,
      ST_WALK_START,
      ST_WALK,
      ST_MUL,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0]   pos;
      logic [COLOR_W-1:0] left_color;
      logic [COLOR_W-1:0] right_color;
   } key_entry_type;

   typedef struct packed {
      logic                 start;
      div_mode_type         mode;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [POS_Q_W-1:0] quo;
   } div_rsp_type;

endpackage

`default_nettype wire

### rtl/tfle_if.sv
// Request, response and register write channel interfaces
`default_nettype none

interface tfle_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [tfle_pkg::SLOT_W-1:0]    key_slot;
   logic [tfle_pkg::POS_W-1:0]     key_position;
   logic [tfle_pkg::COLOR_W-1:0]   left_color;
   logic [tfle_pkg::COLOR_W-1:0]   right_color;
   logic [tfle_pkg::INDEX_W-1:0]   entry_index;

   modport source (output valid, req_type, key_slot, key_position, left_color,
                   right_color, entry_index, input ready);
   modport sink (input valid, req_type, key_slot, key_position, left_color,
                 right_color, entry_index, output ready);
endinterface

interface tfle_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tfle_pkg::INDEX_W-1:0] index_echo;
   logic [tfle_pkg::CHAN_W-1:0]  red;
   logic [tfle_pkg::CHAN_W-1:0]  green;
   logic [tfle_pkg::CHAN_W-1:0]  blue;
   logic [tfle_pkg::CHAN_W-1:0]  alpha;
   logic                         lookup_status;

   modport source (output valid, index_echo, red, green, blue, alpha, lookup_status,
                   input ready);
   modport sink (input valid, index_echo, red, green, blue, alpha, lookup_status,
                 output ready);
endinterface

interface tfle_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tfle_pkg::CSR_ADDR_W-1:0] addr;
   logic [tfle_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### rtl/tfle_ram.sv
// Generic single write port RAM with registered read
`default_nettype none

module tfle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire              clock,
   input  wire              we,
   input  wire [ADDR_W-1:0] waddr,
   input  wire [WIDTH-1:0]  wdata,
   input  wire [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/tfle_div.sv
// Restoring divider, one quotient bit per cycle, position or channel width
`default_nettype none

module tfle_div (
   input  wire                        clock,
   input  wire                        reset,
   input  var tfle_pkg::div_req_type  req,
   output tfle_pkg::div_rsp_type      rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [tfle_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [tfle_pkg::DIV_REM_W-1:0]     rem_ff, rem_in;
   logic [tfle_pkg::DIV_NUM_W-1:0]     sh_ff, sh_in;
   logic [tfle_pkg::POS_Q_W-1:0]       q_ff, q_in;
   logic [tfle_pkg::DIV_DEN_W-1:0]     den_ff, den_in;
   logic [tfle_pkg::DIV_REM_W:0]       trial;
   logic [tfle_pkg::DIV_REM_W:0]       diff;
   logic                               fits;
   logic [tfle_pkg::DIV_NUM_W-1:0]     hi_pos, hi_chan;

   assign trial   = {rem_ff, sh_ff[tfle_pkg::DIV_NUM_W-1]};
   assign diff    = trial - {2'b00, den_ff};
   assign fits    = trial >= {2'b00, den_ff};
   // top bits that stay below the divisor, so only the low quotient bits need steps
   assign hi_pos  = req.num >> tfle_pkg::POS_Q_W;
   assign hi_chan = req.num >> tfle_pkg::CHAN_Q_W;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         q_in    = '0;
         den_in  = req.den;
         if (req.mode == tfle_pkg::DIV_POS) begin
            cnt_in = tfle_pkg::DIV_CNT_W'(tfle_pkg::POS_Q_W);
            rem_in = hi_pos[tfle_pkg::DIV_REM_W-1:0];
            sh_in  = req.num << (tfle_pkg::DIV_NUM_W - tfle_pkg::POS_Q_W);
         end else begin
            cnt_in = tfle_pkg::DIV_CNT_W'(tfle_pkg::CHAN_Q_W);
            rem_in = hi_chan[tfle_pkg::DIV_REM_W-1:0];
            sh_in  = req.num << (tfle_pkg::DIV_NUM_W - tfle_pkg::CHAN_Q_W);
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[tfle_pkg::DIV_REM_W-1:0] : trial[tfle_pkg::DIV_REM_W-1:0];
         sh_in  = sh_ff << 1;
         q_in   = {q_ff[tfle_pkg::POS_Q_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tfle_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = q_ff;

endmodule

`default_nettype wire

### rtl/transfer_function_lut_entry_core.sv
// Top level of the piecewise linear color transfer function lookup
//
//  channel  | dir | word
//  req_ch   | in  | key write (slot, position, colors) or entry lookup (index)
//  rsp_ch   | out | index echo, RGBA, status; one word per lookup
//  csr_ch   | in  | register write: cuts, table size, key count
//
// Key write: written to the key RAM as it is taken. Lookup outside the table or the cuts
// goes from the cut check straight to finish. Lookup inside the cuts, k keys walked (1..16):
// the 17-step position divide and the walk give one key's color; the 8-step divides interpolate.
// Synchronous reset clears registers and control; key RAM holds garbage until written.
// A finished word waits in the output register while the next word is taken; a lookup
// holds in its last state while that register is still full.
`default_nettype none
`include "transfer_function_lut_entry_core_assert.svh"

module transfer_function_lut_entry_core (
   input wire         clock,
   input wire         reset,
   tfle_req_if.sink   req_ch,
   tfle_rsp_if.source rsp_ch,
   tfle_csr_if.sink   csr_ch
);

   // registers
   logic [tfle_pkg::THR_W-1:0]    lthr_ff, rthr_ff;
   logic [tfle_pkg::SIZE_W-1:0]   size_ff;
   logic [tfle_pkg::KCOUNT_W-1:0] kcount_ff;
   logic [tfle_pkg::SIZE_W-1:0]   sz_eff, szm1;
   logic [tfle_pkg::KCOUNT_W-1:0] count_eff;

   // key RAM
   logic                                ram_we;
   logic [tfle_pkg::KEY_IDX_W-1:0]      ram_waddr, ram_raddr;
   tfle_pkg::key_entry_type             ram_wdata, ram_rdata;
   logic [tfle_pkg::KEY_IDX_W+tfle_pkg::SLOT_W-1:0] slot_wide;

   // dividers
   tfle_pkg::div_req_type div_req [tfle_pkg::NUM_CHAN];
   tfle_pkg::div_rsp_type div_rsp [tfle_pkg::NUM_CHAN];
   logic [tfle_pkg::DIV_NUM_W-1:0] chan_num [tfle_pkg::NUM_CHAN];
   logic [tfle_pkg::DIV_NUM_W-1:0] pos_num;
   logic [tfle_pkg::DIV_DEN_W-1:0] pos_den;

   // lookup control
   tfle_pkg::state_type            state_ff, state_in;
   logic [tfle_pkg::INDEX_W-1:0]   idx_ff, idx_in;
   logic [tfle_pkg::SIZE_W-1:0]    front_ff, front_in, back_ff, back_in;
   logic [tfle_pkg::POS_Q_W-1:0]   pos_ff, pos_in;
   logic [tfle_pkg::KEY_IDX_W-1:0] i_ff, i_in;
   logic [tfle_pkg::KEY_IDX_W:0]   i_next;
   logic [tfle_pkg::POS_W-1:0]     prev_pos_ff, prev_pos_in;
   logic [tfle_pkg::COLOR_W-1:0]   prev_right_ff, prev_right_in;
   logic [tfle_pkg::COLOR_W-1:0]   rcol_ff, rcol_in;
   logic [tfle_pkg::POS_W-1:0]     d_ff, d_in, n_ff, n_in, dn_ff, dn_in;
   logic [tfle_pkg::COLOR_W-1:0]   color_ff, color_in;
   tfle_pkg::status_type           status_ff, status_in;

   // output register
   logic                           rsp_valid_ff;
   logic [tfle_pkg::INDEX_W-1:0]   rsp_idx_ff;
   logic [tfle_pkg::COLOR_W-1:0]   rsp_color_ff;
   tfle_pkg::status_type           rsp_status_ff;
   logic                           rsp_free, rsp_load;

   logic                           req_fire, csr_fire, is_lookup;
   logic [tfle_pkg::CUT_PROD_W-1:0] prod_l, prod_r;
   logic [tfle_pkg::CUT_SUM_W-1:0]  sum_l, sum_r;
   logic [tfle_pkg::CUT_W-1:0]      cut_l, cut_r;
   logic [tfle_pkg::SIZE_W-1:0]     front_cut, back_cut;
   logic [tfle_pkg::SIZE_W-1:0]     idx_wide;
   logic                            out_range, in_cuts, hit;

   // ---------------- register file ----------------
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lthr_ff   <= tfle_pkg::LEFT_THR_RESET;
         rthr_ff   <= tfle_pkg::RIGHT_THR_RESET;
         size_ff   <= tfle_pkg::SIZE_RESET;
         kcount_ff <= tfle_pkg::KCOUNT_RESET;
      end else if (csr_fire) begin
         unique case (csr_ch.addr)
            tfle_pkg::CSR_LEFT_THR:   lthr_ff   <= csr_ch.data[tfle_pkg::THR_W-1:0];
            tfle_pkg::CSR_RIGHT_THR:  rthr_ff   <= csr_ch.data[tfle_pkg::THR_W-1:0];
            tfle_pkg::CSR_TABLE_SIZE: size_ff   <= csr_ch.data[tfle_pkg::SIZE_W-1:0];
            tfle_pkg::CSR_KEY_COUNT:  kcount_ff <= csr_ch.data[tfle_pkg::KCOUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      priority if (size_ff < tfle_pkg::SIZE_MIN) begin
         sz_eff = tfle_pkg::SIZE_MIN;
      end else if (size_ff > tfle_pkg::SIZE_MAX) begin
         sz_eff = tfle_pkg::SIZE_MAX;
      end else begin
         sz_eff = size_ff;
      end
   end

   assign count_eff = (kcount_ff > tfle_pkg::COUNT_MAX) ? tfle_pkg::COUNT_MAX : kcount_ff;
   assign szm1      = sz_eff - 1'b1;

   // ---------------- key RAM ----------------
   assign req_ch.ready = (state_ff == tfle_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_lookup    = (req_ch.req_type == tfle_pkg::REQ_LOOKUP);
   assign slot_wide    = {{tfle_pkg::KEY_IDX_W{1'b0}}, req_ch.key_slot};

   assign ram_we    = req_fire && !is_lookup && (slot_wide < tfle_pkg::MAX_KEYS);
   assign ram_waddr = slot_wide[tfle_pkg::KEY_IDX_W-1:0];
   assign ram_wdata = '{pos:         req_ch.key_position,
                        left_color:  req_ch.left_color,
                        right_color: req_ch.right_color};

   tfle_ram #(
      .WIDTH($bits(tfle_pkg::key_entry_type)),
      .DEPTH(tfle_pkg::MAX_KEYS)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------- datapath ----------------
   assign prod_l    = lthr_ff * sz_eff;
   assign prod_r    = rthr_ff * sz_eff;
   assign sum_l     = {1'b0, prod_l} + tfle_pkg::CUT_HALF;
   assign sum_r     = {1'b0, prod_r} + tfle_pkg::CUT_HALF;
   assign cut_l     = sum_l[tfle_pkg::CUT_SUM_W-1:tfle_pkg::THR_W];
   assign cut_r     = sum_r[tfle_pkg::CUT_SUM_W-1:tfle_pkg::THR_W];
   assign front_cut = (cut_l > {1'b0, sz_eff}) ? sz_eff : cut_l[tfle_pkg::SIZE_W-1:0];
   assign back_cut  = (cut_r > {1'b0, sz_eff}) ? sz_eff : cut_r[tfle_pkg::SIZE_W-1:0];

   assign idx_wide  = {1'b0, idx_ff};
   assign out_range = idx_wide >= sz_eff;
   assign in_cuts   = (idx_wide >= front_ff) && (idx_wide < back_ff) && (count_eff != '0);

   // position = (idx * 2^16 + (size-1)/2) / (size-1)
   assign pos_num = {{(tfle_pkg::DIV_NUM_W-tfle_pkg::INDEX_W-tfle_pkg::POS_W){1'b0}},
                     idx_ff, {tfle_pkg::POS_W{1'b0}}}
                  + {{(tfle_pkg::DIV_NUM_W-tfle_pkg::SIZE_W+1){1'b0}},
                     szm1[tfle_pkg::SIZE_W-1:1]};
   assign pos_den = {{(tfle_pkg::DIV_DEN_W-tfle_pkg::SIZE_W){1'b0}}, szm1};

   assign hit    = {1'b0, ram_rdata.pos} >= pos_ff;
   assign i_next = {1'b0, i_ff} + 1'b1;

   // per channel: L*(d-n) + R*n + d/2
   always_comb begin
      logic [tfle_pkg::PROD_W-1:0] lp, rp;
      for (int k = 0; k < tfle_pkg::NUM_CHAN; k++) begin
         lp = prev_right_ff[tfle_pkg::COLOR_W-1-tfle_pkg::CHAN_W*k -: tfle_pkg::CHAN_W]
              * dn_ff;
         rp = rcol_ff[tfle_pkg::COLOR_W-1-tfle_pkg::CHAN_W*k -: tfle_pkg::CHAN_W] * n_ff;
         chan_num[k] = {{(tfle_pkg::DIV_NUM_W-tfle_pkg::PROD_W){1'b0}}, lp}
                     + {{(tfle_pkg::DIV_NUM_W-tfle_pkg::PROD_W){1'b0}}, rp}
                     + {{(tfle_pkg::DIV_NUM_W-tfle_pkg::POS_W+1){1'b0}},
                        d_ff[tfle_pkg::POS_W-1:1]};
      end
   end

   for (genvar g = 0; g < tfle_pkg::NUM_CHAN; g++) begin : g_lane
      tfle_div u_div (
         .clock (clock),
         .reset (reset),
         .req   (div_req[g]),
         .rsp   (div_rsp[g])
      );
   end

   // ---------------- control ----------------
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load = (state_ff == tfle_pkg::ST_FINISH) && rsp_free;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      pos_in        = pos_ff;
      i_in          = i_ff;
      prev_pos_in   = prev_pos_ff;
      prev_right_in = prev_right_ff;
      rcol_in       = rcol_ff;
      d_in          = d_ff;
      n_in          = n_ff;
      dn_in         = dn_ff;
      color_in      = color_ff;
      status_in     = status_ff;
      ram_raddr     = '0;
      for (int k = 0; k < tfle_pkg::NUM_CHAN; k++) begin
         div_req[k].start = 1'b0;
         div_req[k].mode  = tfle_pkg::DIV_CHAN;
         div_req[k].num   = chan_num[k];
         div_req[k].den   = d_ff;
      end

      unique case (state_ff)
         tfle_pkg::ST_IDLE: begin
            if (req_fire && is_lookup) begin
               idx_in    = req_ch.entry_index;
               color_in  = '0;
               status_in = tfle_pkg::STATUS_OK;
               state_in  = tfle_pkg::ST_CUTS;
            end
         end
         tfle_pkg::ST_CUTS: begin
            front_in = front_cut;
            back_in  = back_cut;
            state_in = tfle_pkg::ST_CHECK;
         end
         tfle_pkg::ST_CHECK: begin
            priority if (out_range) begin
               status_in = tfle_pkg::STATUS_RANGE;
               state_in  = tfle_pkg::ST_FINISH;
            end else if (in_cuts) begin
               div_req[0].start = 1'b1;
               div_req[0].mode  = tfle_pkg::DIV_POS;
               div_req[0].num   = pos_num;
               div_req[0].den   = pos_den;
               state_in         = tfle_pkg::ST_POS_WAIT;
            end else begin
               state_in = tfle_pkg::ST_FINISH;
            end
         end
         tfle_pkg::ST_POS_WAIT: begin
            if (div_rsp[0].done) begin
               pos_in   = div_rsp[0].quo;
               state_in = tfle_pkg::ST_WALK_START;
            end
         end
         tfle_pkg::ST_WALK_START: begin
            ram_raddr = '0;
            i_in      = '0;
            state_in  = tfle_pkg::ST_WALK;
         end
         tfle_pkg::ST_WALK: begin
            ram_raddr = i_next[tfle_pkg::KEY_IDX_W-1:0];
            priority if (hit && (i_ff == '0)) begin
               color_in = ram_rdata.left_color;
               state_in = tfle_pkg::ST_FINISH;
            end else if (hit) begin
               d_in     = ram_rdata.pos - prev_pos_ff;
               n_in     = pos_ff[tfle_pkg::POS_W-1:0] - prev_pos_ff;
               dn_in    = ram_rdata.pos - pos_ff[tfle_pkg::POS_W-1:0];
               rcol_in  = ram_rdata.left_color;
               state_in = tfle_pkg::ST_MUL;
            end else begin
               prev_pos_in   = ram_rdata.pos;
               prev_right_in = ram_rdata.right_color;
               if (i_next == count_eff) begin
                  color_in = ram_rdata.right_color;
                  state_in = tfle_pkg::ST_FINISH;
               end else begin
                  i_in = i_next[tfle_pkg::KEY_IDX_W-1:0];
               end
            end
         end
         tfle_pkg::ST_MUL: begin
            for (int k = 0; k < tfle_pkg::NUM_CHAN; k++) begin
               div_req[k].start = 1'b1;
            end
            state_in = tfle_pkg::ST_DIV_WAIT;
         end
         tfle_pkg::ST_DIV_WAIT: begin
            if (div_rsp[0].done) begin
               for (int k = 0; k < tfle_pkg::NUM_CHAN; k++) begin
                  color_in[tfle_pkg::COLOR_W-1-tfle_pkg::CHAN_W*k -: tfle_pkg::CHAN_W] =
                     div_rsp[k].quo[tfle_pkg::CHAN_W-1:0];
               end
               state_in = tfle_pkg::ST_FINISH;
            end
         end
         tfle_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = tfle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tfle_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tfle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      front_ff      <= front_in;
      back_ff       <= back_in;
      pos_ff        <= pos_in;
      i_ff          <= i_in;
      prev_pos_ff   <= prev_pos_in;
      prev_right_ff <= prev_right_in;
      rcol_ff       <= rcol_in;
      d_ff          <= d_in;
      n_ff          <= n_in;
      dn_ff         <= dn_in;
      color_ff      <= color_in;
      status_ff     <= status_in;
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_idx_ff    <= idx_ff;
         rsp_color_ff  <= color_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.index_echo    = rsp_idx_ff;
   assign rsp_ch.red           = rsp_color_ff[31:24];
   assign rsp_ch.green         = rsp_color_ff[23:16];
   assign rsp_ch.blue          = rsp_color_ff[15:8];
   assign rsp_ch.alpha         = rsp_color_ff[7:0];
   assign rsp_ch.lookup_status = rsp_status_ff;

   // ---------------- assertions ----------------
   `TFLE_ASSERT_IMPL(a_div_done_waited, div_rsp[0].done,
      (state_ff == tfle_pkg::ST_POS_WAIT) || (state_ff == tfle_pkg::ST_DIV_WAIT),
      "divider finished while control was not waiting")
   `TFLE_ASSERT_IMPL(a_walk_below_count, state_ff == tfle_pkg::ST_WALK,
      i_ff < count_eff, "key walk beyond key count")
   `TFLE_ASSERT_NEXT(a_finish_loads_rsp, rsp_load,
      rsp_valid_ff && (state_ff == tfle_pkg::ST_IDLE), "finished word not presented")
   `TFLE_ASSERT_IMPL(a_lanes_in_step, state_ff == tfle_pkg::ST_DIV_WAIT,
      (div_rsp[1].done == div_rsp[0].done) && (div_rsp[2].done == div_rsp[0].done) &&
      (div_rsp[3].done == div_rsp[0].done), "channel dividers out of step")

endmodule

`default_nettype wire

### verif/transfer_function_lut_entry_core_tb.sv
// Self-checking testbench of the transfer function lookup core: directed and random words
`default_nettype none

module transfer_function_lut_entry_core_tb;
   import tfle_pkg::*;

   localparam int SETTLE_CYCLES = 60;
   localparam int IDLE_LIMIT    = 5000;
   localparam int RANDOM_PHASES = 20;
   localparam int PHASE_WORDS   = 42;

   typedef struct packed {
      req_kind_type         kind;
      logic [SLOT_W-1:0]    slot;
      logic [POS_W-1:0]     position;
      logic [COLOR_W-1:0]   left_col;
      logic [COLOR_W-1:0]   right_col;
      logic [INDEX_W-1:0]   index;
   } lut_word_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index_echo;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [CHAN_W-1:0]  alpha;
      status_type         status;
   } entry_color_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfle_req_if req_ch ();
   tfle_rsp_if rsp_ch ();
   tfle_csr_if csr_ch ();

   transfer_function_lut_entry_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow of the key store and registers
   logic [POS_W-1:0]    key_pos_mem   [MAX_KEYS];
   logic [COLOR_W-1:0]  key_left_mem  [MAX_KEYS];
   logic [COLOR_W-1:0]  key_right_mem [MAX_KEYS];
   logic [THR_W-1:0]    lo_thr_reg;
   logic [THR_W-1:0]    hi_thr_reg;
   logic [SIZE_W-1:0]   size_reg;
   logic [KCOUNT_W-1:0] count_reg;

   entry_color_type pending_colors [$];
   int fail_count  = 0;
   int burst_left  = 0;
   int idle_cycles = 0;
   bit no_gaps     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned eff_size(input logic [SIZE_W-1:0] s);
      longint unsigned v;
      v = 64'(s);
      if (v < 64'(SIZE_MIN)) v = 64'(SIZE_MIN);
      if (v > 64'(SIZE_MAX)) v = 64'(SIZE_MAX);
      return v;
   endfunction

   function automatic longint unsigned cut_of(input logic [THR_W-1:0] frac,
                                              input longint unsigned size);
      longint unsigned f, c;
      f = 64'(frac);
      c = (f * size + 32768) >> 16;
      return (c > size) ? size : c;
   endfunction

   function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color, input int ch);
      return color[COLOR_W-1-CHAN_W*ch -: CHAN_W];
   endfunction

   function automatic entry_color_type predict_entry(input logic [INDEX_W-1:0] idx);
      entry_color_type res;
      longint unsigned size, front, back, pos, idx_l, pl, d, n, lc, rc;
      int              count, hit;
      logic [CHAN_W-1:0] col [NUM_CHAN];
      for (int ch = 0; ch < NUM_CHAN; ch++) col[ch] = '0;
      size  = eff_size(size_reg);
      count = (count_reg > COUNT_MAX) ? MAX_KEYS : int'(count_reg);
      idx_l = 64'(idx);
      res.index_echo = idx;
      res.status     = STATUS_OK;
      if (idx_l >= size) begin
         res.status = STATUS_RANGE;
      end else begin
         front = cut_of(lo_thr_reg, size);
         back  = cut_of(hi_thr_reg, size);
         if (idx_l >= front && idx_l < back && count > 0) begin
            pos = (idx_l * 65536 + (size - 1) / 2) / (size - 1);
            hit = count;
            for (int k = count - 1; k >= 0; k--) begin
               if (64'(key_pos_mem[k]) >= pos) hit = k;
            end
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
               if (hit == 0) begin
                  col[ch] = chan_of(key_left_mem[0], ch);
               end else if (hit == count) begin
                  col[ch] = chan_of(key_right_mem[count-1], ch);
               end else begin
                  pl = 64'(key_pos_mem[hit-1]);
                  d  = 64'(key_pos_mem[hit]) - pl;
                  n  = pos - pl;
                  lc = 64'(chan_of(key_right_mem[hit-1], ch));
                  rc = 64'(chan_of(key_left_mem[hit], ch));
                  col[ch] = CHAN_W'((lc * (d - n) + rc * n + d / 2) / d);
               end
            end
         end
      end
      res.red   = col[0];
      res.green = col[1];
      res.blue  = col[2];
      res.alpha = col[3];
      return res;
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin : check_rsp
      entry_color_type exp_c;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_colors.size() == 0) begin
            $error("unexpected result word, index_echo %0d", rsp_ch.index_echo);
            fail_count++;
         end else begin
            exp_c = pending_colors.pop_front();
            check_field("index_echo", 32'(exp_c.index_echo), 32'(rsp_ch.index_echo));
            check_field("red", 32'(exp_c.red), 32'(rsp_ch.red));
            check_field("green", 32'(exp_c.green), 32'(rsp_ch.green));
            check_field("blue", 32'(exp_c.blue), 32'(rsp_ch.blue));
            check_field("alpha", 32'(exp_c.alpha), 32'(rsp_ch.alpha));
            check_field("lookup_status", 32'(exp_c.status), 32'(rsp_ch.lookup_status));
         end
      end
   end

   // receiver stalls in runs
   initial begin : rsp_stall
      int run_left;
      run_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (run_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
               rsp_ch.ready <= 1'b1;
               run_left = $urandom_range(1, 40);
            end else begin
               rsp_ch.ready <= 1'b0;
               run_left = $urandom_range(1, 20);
            end
         end else begin
            run_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("transfer_function_lut_entry_core_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input lut_word_type w);
      csr_ch.valid <= 1'b0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (!no_gaps) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= w.kind;
      req_ch.key_slot     <= w.slot;
      req_ch.key_position <= w.position;
      req_ch.left_color   <= w.left_col;
      req_ch.right_color  <= w.right_col;
      req_ch.entry_index  <= w.index;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      if (w.kind == REQ_WRITE_KEY) begin
         key_pos_mem[w.slot]   = w.position;
         key_left_mem[w.slot]  = w.left_col;
         key_right_mem[w.slot] = w.right_col;
      end else begin
         pending_colors = {pending_colors, predict_entry(w.index)};
      end
   endtask

   task automatic write_key(input logic [SLOT_W-1:0] slot, input logic [POS_W-1:0] pos,
                            input logic [COLOR_W-1:0] lc, input logic [COLOR_W-1:0] rc);
      lut_word_type w;
      w.kind      = REQ_WRITE_KEY;
      w.slot      = slot;
      w.position  = pos;
      w.left_col  = lc;
      w.right_col = rc;
      w.index     = INDEX_W'($urandom);
      send_item(w);
   endtask

   task automatic look_up_entry(input logic [INDEX_W-1:0] idx);
      lut_word_type w;
      w.kind      = REQ_LOOKUP;
      w.slot      = SLOT_W'($urandom);
      w.position  = POS_W'($urandom);
      w.left_col  = $urandom;
      w.right_col = $urandom;
      w.index     = idx;
      send_item(w);
   endtask

   task automatic write_reg(input csr_addr_type addr, input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= addr;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (addr)
         CSR_LEFT_THR:   lo_thr_reg = data[THR_W-1:0];
         CSR_RIGHT_THR:  hi_thr_reg = data[THR_W-1:0];
         CSR_TABLE_SIZE: size_reg   = data[SIZE_W-1:0];
         CSR_KEY_COUNT:  count_reg  = data[KCOUNT_W-1:0];
         default: ;
      endcase
   endtask

   // drain all results, then let the core go idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      csr_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic rewrite_keys();
      int unsigned lo, hi;
      int unsigned pos_q [$];
      lo = $urandom_range(0, 65535);
      hi = $urandom_range(lo, 65535);
      if ($urandom_range(0, 2) == 0) begin
         lo = 0;
         hi = 65535;
      end
      for (int k = 0; k < MAX_KEYS; k++) pos_q = {pos_q, $urandom_range(lo, hi)};
      pos_q.sort();
      for (int k = 0; k < MAX_KEYS; k++) begin
         write_key(SLOT_W'(k), POS_W'(pos_q[k]), pick_color(), pick_color());
      end
   endtask

   task automatic test_zero_keys();
      look_up_entry(0);
      look_up_entry(128);
      look_up_entry(255);
      look_up_entry(256);
      look_up_entry(1023);
   endtask

   task automatic test_key_segments();
      write_key(0, 16'd0, 32'hFFFF_FFFF, 32'h0000_0000);
      write_key(1, 16'd21845, 32'hFFFF_FFFF, 32'h80FF_4010);
      write_key(2, 16'd43690, 32'h1234_5678, 32'hFF00_FF00);
      write_key(3, 16'd65535, 32'h0000_0000, 32'hFFFF_FFFF);
      settle();
      write_reg(CSR_KEY_COUNT, 16'd4);
      look_up_entry(0);
      look_up_entry(40);
      look_up_entry(200);
      look_up_entry(255);
   endtask

   task automatic test_cuts();
      settle();
      write_reg(CSR_LEFT_THR, 16'd16384);
      write_reg(CSR_RIGHT_THR, 16'd49152);
      look_up_entry(63);
      look_up_entry(64);
      look_up_entry(191);
      look_up_entry(192);
      settle();
      write_reg(CSR_LEFT_THR, 16'hFFFF);
      write_reg(CSR_RIGHT_THR, 16'h0000);
      look_up_entry(128);
      look_up_entry(300);
      settle();
      write_reg(CSR_LEFT_THR, 16'h0000);
      write_reg(CSR_RIGHT_THR, 16'hFFFF);
   endtask

   task automatic test_table_size();
      settle();
      write_reg(CSR_TABLE_SIZE, 16'd0);
      look_up_entry(1);
      look_up_entry(2);
      settle();
      write_reg(CSR_TABLE_SIZE, 16'hFFFF);
      look_up_entry(512);
      look_up_entry(1023);
   endtask

   task automatic test_random();
      logic [CSR_DATA_W-1:0] lt, rt, sz, kc;
      longint unsigned       es;
      int                    r;
      rewrite_keys();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin lt = '0; rt = 16'hFFFF; sz = 16'd1024; kc = 16'd16; end
            1: begin lt = '0; rt = '0; sz = 16'd2; kc = 16'd1; end
            2: begin lt = 16'hFFFF; rt = 16'hFFFF; sz = 16'h07FF; kc = 16'd31; end
            3: begin lt = '0; rt = 16'hFFFF; sz = 16'd0; kc = 16'd0; end
            4: begin lt = '0; rt = 16'hFFFF; sz = 16'd1; kc = 16'hFFFF; end
            default: begin
               r = $urandom_range(0, 9);
               if (r < 5) begin
                  lt = CSR_DATA_W'($urandom_range(0, 4000));
                  rt = CSR_DATA_W'($urandom_range(61000, 65535));
               end else if (r < 7) begin
                  lt = CSR_DATA_W'($urandom);
                  rt = CSR_DATA_W'($urandom);
               end else if (r < 8) begin
                  lt = '0;
                  rt = 16'hFFFF;
               end else begin
                  lt = CSR_DATA_W'($urandom_range(0, 30000));
                  rt = CSR_DATA_W'($urandom_range(30000, 65535));
               end
               r = $urandom_range(0, 9);
               if (r < 4) begin
                  sz = CSR_DATA_W'($urandom_range(2, 1024));
               end else if (r < 7) begin
                  sz = CSR_DATA_W'($urandom_range(2, 16));
               end else begin
                  case ($urandom_range(0, 5))
                     0: sz = 16'd1;
                     1: sz = 16'd1023;
                     2: sz = 16'd1024;
                     3: sz = 16'd1025;
                     4: sz = 16'd3;
                     default: sz = CSR_DATA_W'($urandom);
                  endcase
               end
               r = $urandom_range(0, 9);
               if (r < 7) kc = CSR_DATA_W'($urandom_range(1, 16));
               else if (r < 8) kc = '0;
               else kc = CSR_DATA_W'($urandom);
            end
         endcase
         settle();
         no_gaps = ($urandom_range(0, 3) == 0);
         write_reg(CSR_LEFT_THR, lt);
         write_reg(CSR_RIGHT_THR, rt);
         write_reg(CSR_TABLE_SIZE, sz);
         write_reg(CSR_KEY_COUNT, kc);
         es = eff_size(size_reg);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               rewrite_keys();
            end else if (r < 9) begin
               write_key(SLOT_W'($urandom), POS_W'($urandom), pick_color(), pick_color());
            end else if (r < 18) begin
               look_up_entry(INDEX_W'(es - 1));
            end else if (r < 88) begin
               look_up_entry(INDEX_W'($urandom_range(0, 32'(es - 1))));
            end else begin
               look_up_entry(INDEX_W'($urandom));
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= REQ_LOOKUP;
      req_ch.key_slot     <= '0;
      req_ch.key_position <= '0;
      req_ch.left_color   <= '0;
      req_ch.right_color  <= '0;
      req_ch.entry_index  <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.addr         <= CSR_LEFT_THR;
      csr_ch.data         <= '0;
      lo_thr_reg = LEFT_THR_RESET;
      hi_thr_reg = RIGHT_THR_RESET;
      size_reg   = SIZE_RESET;
      count_reg  = KCOUNT_RESET;
      for (int k = 0; k < MAX_KEYS; k++) begin
         key_pos_mem[k]   = '0;
         key_left_mem[k]  = '0;
         key_right_mem[k] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_zero_keys();
      test_key_segments();
      test_cuts();
      test_table_size();
      test_random();
      settle();
      if (pending_colors.size() != 0) begin
         $error("%0d expected result words never arrived", pending_colors.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("transfer_function_lut_entry_core_tb: PASS");
      end else begin
         $display("transfer_function_lut_entry_core_tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
